// ----- design/dhkt_pkg.sv -----
// dhkt_pkg: shared types and codes for the double-hash key table
// no dependencies
package dhkt_pkg;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_LOOKUP = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;
    localparam logic [1:0] ACT_NEXT   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_BADLEN   = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic [0:0] CFG_MAX_LIVE   = 1'b0;
    localparam logic [0:0] CFG_DATA_BYTES = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // capture item, start modulo units
        logic clr_step;   // clearing pass: write one slot as unused
        logic rd;         // read slot at probe or scan address
        logic adv;        // move to next probe / scan address
        logic wr_ins;     // write insert at probe address
        logic wr_rem;     // tombstone at probe address
        logic fin;        // latch result
        logic [1:0] fin_status;
        logic fin_hit;    // result carries slot data or key
    } dhkt_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic mod_done;
        logic clr_last;
        logic act_bad_len;
        logic at_limit;
        logic slot_used;
        logic slot_live;
        logic key_match;
        logic wrapped;     // next probe address equals start
        logic scan_end;    // scan address at or past table end
        logic [1:0] action;
    } dhkt_stat_t;

endpackage

// ----- design/double_hash_key_table.sv -----
// double_hash_key_table: open-addressing key table with double hashing. After reset a clearing
// pass marks all TABLE_SIZE slots (1153 by default) unused; no item is taken then. An item
// first reduces its key by both moduli, 16 key bits at a time (quotient estimate, then
// remainder), then probes with a registered slot read followed by a compare. An insert with
// a bad length or at the live limit is refused without a probe; a next scan reads slots
// upward from start_index until a live one or the table end. One item is worked at a time;
// the result waits in the output register and no item is taken until it is accepted.
// depends on dhkt_pkg, dhkt_ctrl, dhkt_datapath
module double_hash_key_table #(
    parameter int TABLE_SIZE = 1153,
    parameter int REHASH_MOD = 1151
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [63:0] key_hash,
    input  logic [63:0] data_word,
    input  logic [3:0]  data_len,
    input  logic [10:0] start_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [63:0] out_data,
    output logic [3:0]  out_length,
    output logic [63:0] out_key,
    output logic [10:0] resume_index,
    output logic [10:0] live_entries
);
    localparam int AW = $clog2(TABLE_SIZE);

    dhkt_pkg::dhkt_cmd_t  cmd;
    dhkt_pkg::dhkt_stat_t stat;

    dhkt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    dhkt_datapath #(
        .TABLE_SIZE (TABLE_SIZE),
        .REHASH_MOD (REHASH_MOD),
        .AW         (AW)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_idx     (cfg_index),
        .cfg_data    (cfg_data),
        .action      (action),
        .key_hash    (key_hash),
        .data_word   (data_word),
        .data_len    (data_len),
        .start_index (start_index),
        .cmd         (cmd),
        .stat        (stat),
        .r_status    (status),
        .r_data      (out_data),
        .r_length    (out_length),
        .r_key       (out_key),
        .r_resume    (resume_index),
        .r_live      (live_entries)
    );
endmodule

// ----- design/dhkt_datapath.sv -----
// dhkt_datapath: slot memories, modulo units, probe address and counters
// depends on dhkt_pkg
module dhkt_datapath #(
    parameter int TABLE_SIZE = 1153,
    parameter int REHASH_MOD = 1151,
    parameter int AW = 11
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_idx,
    input  logic [10:0]          cfg_data,
    input  logic [1:0]           action,
    input  logic [63:0]          key_hash,
    input  logic [63:0]          data_word,
    input  logic [3:0]           data_len,
    input  logic [10:0]          start_index,
    input  dhkt_pkg::dhkt_cmd_t  cmd,
    output dhkt_pkg::dhkt_stat_t stat,
    output logic [1:0]           r_status,
    output logic [63:0]          r_data,
    output logic [3:0]           r_length,
    output logic [63:0]          r_key,
    output logic [10:0]          r_resume,
    output logic [10:0]          r_live
);
    localparam int CW = AW + 1;
    localparam int XW = AW + 16;
    localparam logic [CW-1:0] TS = CW'(TABLE_SIZE);
    localparam logic [XW-1:0] TS_X = XW'(TABLE_SIZE);
    localparam logic [XW-1:0] RM_X = XW'(REHASH_MOD);
    // reciprocals scaled by 2^XW, estimate is low by at most one
    localparam logic [XW-1:0] RCP_T = XW'((64'd1 << XW) / 64'(TABLE_SIZE));
    localparam logic [XW-1:0] RCP_S = XW'((64'd1 << XW) / 64'(REHASH_MOD));

    logic [63:0] slot_key_mem [TABLE_SIZE];
    logic [63:0] slot_data_mem [TABLE_SIZE];
    logic [4:0]  slot_lu_mem [TABLE_SIZE];   // {used, len}
    logic [63:0] rd_key_reg, rd_data_reg;
    logic [4:0]  rd_lu_reg;

    logic [10:0] max_live_reg;
    logic [3:0]  data_bytes_reg;
    logic [10:0] live_reg, tomb_reg;

    logic [1:0]  act_reg;
    logic [63:0] key_reg, data_reg;
    logic [3:0]  len_reg;

    // remainders of key by table size and by rehash modulus, 16 key bits at a time
    logic [AW-1:0] rem_t_reg, rem_s_reg;
    logic [XW-1:0] q_t_reg, q_s_reg;
    logic [2:0]    mod_cnt_reg;
    logic          mod_busy_reg;

    logic [AW-1:0] addr_reg, start_reg, step_reg, clr_reg;
    logic [CW-1:0] scan_reg;

    logic [15:0]     chunk;
    logic [XW-1:0]   x_t, x_s;
    logic [2*XW-1:0] p_t, p_s;
    logic [XW-1:0]   d_t, d_s;
    logic [AW-1:0]   rt_next, rs_next;
    logic [CW:0] nsum;
    logic [AW-1:0] naddr;
    logic [3:0] lim;
    logic [63:0] mask;

    always_comb
    begin
        case (mod_cnt_reg[2:1])
            2'd0:    chunk = key_reg[63:48];
            2'd1:    chunk = key_reg[47:32];
            2'd2:    chunk = key_reg[31:16];
            default: chunk = key_reg[15:0];
        endcase
    end

    assign x_t = {rem_t_reg, chunk};
    assign x_s = {rem_s_reg, chunk};
    assign p_t = (2*XW)'(x_t) * (2*XW)'(RCP_T);
    assign p_s = (2*XW)'(x_s) * (2*XW)'(RCP_S);
    assign d_t = x_t - q_t_reg * TS_X;
    assign d_s = x_s - q_s_reg * RM_X;
    assign rt_next = (d_t >= TS_X) ? AW'(d_t - TS_X) : AW'(d_t);
    assign rs_next = (d_s >= RM_X) ? AW'(d_s - RM_X) : AW'(d_s);

    assign nsum = (CW+1)'(addr_reg) + (CW+1)'(step_reg);
    assign naddr = (nsum >= (CW+1)'(TABLE_SIZE)) ? AW'(nsum - (CW+1)'(TABLE_SIZE))
                                                 : AW'(nsum);
    assign lim = (data_bytes_reg > 4'd8) ? 4'd8 : data_bytes_reg;
    assign mask = (len_reg >= 4'd8) ? '1 : ((64'd1 << {len_reg[2:0], 3'b000}) - 64'd1);

    always_comb
    begin
        stat.mod_done    = !mod_busy_reg;
        stat.clr_last    = (clr_reg == AW'(TABLE_SIZE - 1));
        stat.act_bad_len = (len_reg == 4'd0) || (len_reg > lim);
        stat.at_limit    = (live_reg >= max_live_reg);
        stat.slot_used   = rd_lu_reg[4];
        stat.slot_live   = (rd_lu_reg[3:0] != 4'd0);
        stat.key_match   = (rd_key_reg == key_reg);
        stat.wrapped     = (naddr == start_reg);
        stat.scan_end    = (scan_reg >= TS);
        stat.action      = act_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_live_reg   <= 11'd1024;
            data_bytes_reg <= 4'd8;
            live_reg       <= '0;
            tomb_reg       <= '0;
            mod_busy_reg   <= 1'b0;
            clr_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_idx == dhkt_pkg::CFG_MAX_LIVE)
                    max_live_reg <= cfg_data;
                else
                    data_bytes_reg <= cfg_data[3:0];
            end
            if (cmd.clr_step)
                clr_reg <= clr_reg + AW'(1);
            if (cmd.load)
                mod_busy_reg <= 1'b1;
            else if (mod_busy_reg && mod_cnt_reg == 3'd7)
                mod_busy_reg <= 1'b0;
            if (cmd.wr_ins)
            begin
                live_reg <= live_reg + 11'd1;
                if (rd_lu_reg[4] && tomb_reg != 11'd0)
                    tomb_reg <= tomb_reg - 11'd1;
            end
            if (cmd.wr_rem)
            begin
                if (live_reg != 11'd0)
                    live_reg <= live_reg - 11'd1;
                tomb_reg <= tomb_reg + 11'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg     <= action;
            key_reg     <= key_hash;
            data_reg    <= data_word;
            len_reg     <= data_len;
            rem_t_reg   <= '0;
            rem_s_reg   <= '0;
            mod_cnt_reg <= '0;
            scan_reg    <= CW'(start_index);
        end
        else if (mod_busy_reg)
        begin
            mod_cnt_reg <= mod_cnt_reg + 3'd1;
            // even cycle: quotient estimate, odd cycle: remainder with one correction
            if (!mod_cnt_reg[0])
            begin
                q_t_reg <= p_t[2*XW-1:XW];
                q_s_reg <= p_s[2*XW-1:XW];
            end
            else
            begin
                rem_t_reg <= rt_next;
                rem_s_reg <= rs_next;
            end
            if (mod_cnt_reg == 3'd7)
            begin
                addr_reg  <= rt_next;
                start_reg <= rt_next;
                step_reg  <= (rs_next == '0) ? AW'(1) : rs_next;
            end
        end
        if (cmd.adv)
        begin
            if (act_reg == dhkt_pkg::ACT_NEXT)
                scan_reg <= scan_reg + CW'(1);
            else
                addr_reg <= naddr;
        end
        // slot memories: one port each
        if (cmd.clr_step)
            slot_lu_mem[clr_reg] <= 5'd0;
        else if (cmd.wr_ins)
        begin
            slot_lu_mem[addr_reg]   <= {1'b1, len_reg};
            slot_key_mem[addr_reg]  <= key_reg;
            slot_data_mem[addr_reg] <= data_reg & mask;
        end
        else if (cmd.wr_rem)
            slot_lu_mem[addr_reg] <= {1'b1, 4'd0};
        if (cmd.rd)
        begin
            rd_lu_reg   <= slot_lu_mem[(act_reg == dhkt_pkg::ACT_NEXT) ? AW'(scan_reg) : addr_reg];
            rd_key_reg  <= slot_key_mem[(act_reg == dhkt_pkg::ACT_NEXT) ? AW'(scan_reg) : addr_reg];
            rd_data_reg <= slot_data_mem[addr_reg];
        end
        if (cmd.fin)
        begin
            r_status <= cmd.fin_status;
            r_data   <= '0;
            r_length <= '0;
            r_key    <= '0;
            r_resume <= '0;
            if (cmd.fin_hit && act_reg == dhkt_pkg::ACT_LOOKUP)
            begin
                r_data   <= rd_data_reg;
                r_length <= rd_lu_reg[3:0];
            end
            if (cmd.fin_hit && act_reg == dhkt_pkg::ACT_NEXT)
            begin
                r_key    <= rd_key_reg;
                r_resume <= 11'(scan_reg + CW'(1));
            end
        end
    end

    // live count seen after this item's own update
    assign r_live = live_reg;
endmodule

// ----- design/dhkt_ctrl.sv -----
// dhkt_ctrl: sequencer for clearing pass, probe loop and result handoff
// depends on dhkt_pkg
module dhkt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  dhkt_pkg::dhkt_stat_t stat,
    output dhkt_pkg::dhkt_cmd_t  cmd
);
    typedef enum logic [6:0] {
        S_CLR  = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_MOD  = 7'b0000100,
        S_RD   = 7'b0001000,
        S_EVAL = 7'b0010000,
        S_SCAN = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (stat.action == dhkt_pkg::ACT_NEXT)
                    state_next = S_SCAN;
                else if (stat.action == dhkt_pkg::ACT_INSERT && stat.act_bad_len)
                begin
                    cmd.fin = 1'b1;
                    cmd.fin_status = dhkt_pkg::ST_BADLEN;
                    state_next = S_OUT;
                end
                else if (stat.action == dhkt_pkg::ACT_INSERT && stat.at_limit)
                begin
                    cmd.fin = 1'b1;
                    cmd.fin_status = dhkt_pkg::ST_FULL;
                    state_next = S_OUT;
                end
                else if (stat.mod_done)
                    state_next = S_RD;
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.fin_status = dhkt_pkg::ST_NOTFOUND;
                state_next = S_OUT;
                case (stat.action)
                    dhkt_pkg::ACT_INSERT:
                    begin
                        if (!stat.slot_live)
                        begin
                            cmd.wr_ins = 1'b1;
                            cmd.fin_status = dhkt_pkg::ST_OK;
                            cmd.fin = 1'b1;
                        end
                        else if (stat.wrapped)
                        begin
                            cmd.fin_status = dhkt_pkg::ST_FULL;
                            cmd.fin = 1'b1;
                        end
                        else
                        begin
                            cmd.adv = 1'b1;
                            state_next = S_RD;
                        end
                    end
                    dhkt_pkg::ACT_LOOKUP, dhkt_pkg::ACT_REMOVE:
                    begin
                        if (!stat.slot_used)
                            cmd.fin = 1'b1;
                        else if (stat.slot_live && stat.key_match)
                        begin
                            cmd.fin = 1'b1;
                            cmd.fin_hit = 1'b1;
                            cmd.fin_status = dhkt_pkg::ST_OK;
                            cmd.wr_rem = (stat.action == dhkt_pkg::ACT_REMOVE);
                        end
                        else if (stat.wrapped)
                            cmd.fin = 1'b1;
                        else
                        begin
                            cmd.adv = 1'b1;
                            state_next = S_RD;
                        end
                    end
                    default:
                    begin
                        if (stat.slot_live)
                        begin
                            cmd.fin = 1'b1;
                            cmd.fin_hit = 1'b1;
                            cmd.fin_status = dhkt_pkg::ST_OK;
                        end
                        else
                        begin
                            cmd.adv = 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                endcase
            end
            S_SCAN:
            begin
                // scan stops at the table end with nothing found
                if (stat.scan_end)
                begin
                    cmd.fin = 1'b1;
                    cmd.fin_status = dhkt_pkg::ST_NOTFOUND;
                    state_next = S_OUT;
                end
                else
                    state_next = S_RD;
            end
            S_OUT:
            begin
                out_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

// ----- design/dhkt_checker.sv -----
// dhkt_checker: port-level checks for the key table
// depends on double_hash_key_table ports
module dhkt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [3:0]  out_length,
    input logic [10:0] resume_index
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result dropped while stalled");
    a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken with result pending");
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != dhkt_pkg::ST_OK |-> out_length == 4'd0 && resume_index == 11'd0)
        else $error("miss carries data");
endmodule

bind double_hash_key_table dhkt_checker u_chk (.*);

// ----- tb/sv/tb_double_hash_key_table.sv -----
`timescale 1ns / 1ps
// tb_double_hash_key_table: self-checking bench for the double-hash key table
// drives random and directed actions, predicts each result with a table model in the class
// depends on dhkt_pkg and double_hash_key_table
module tb_double_hash_key_table;

    localparam int TBL_SLOTS = 1153;
    localparam int STEP_MOD = 1151;
    localparam longint CYCLE_LIMIT = 50000000;

    typedef struct {
        logic [1:0]  action;
        logic [63:0] key;
        logic [63:0] data;
        logic [3:0]  len;
        logic [10:0] sidx;
    } table_req_t;

    typedef struct {
        logic [1:0]  status;
        logic [63:0] odata;
        logic [3:0]  olen;
        logic [63:0] okey;
        logic [10:0] resume;
        logic [10:0] live;
    } table_rsp_t;

    // table model plus queue of predicted responses
    class key_table_board;
        logic [63:0] s_key[TBL_SLOTS];
        logic [63:0] s_data[TBL_SLOTS];
        logic [3:0]  s_len[TBL_SLOTS];
        bit          s_used[TBL_SLOTS];
        int          live_cnt;
        int          tomb_cnt;
        int          max_live;
        int          data_bytes;
        table_rsp_t  pending_rsp[$];
        int          errors;

        function void clear();
            for (int i = 0; i < TBL_SLOTS; i++)
            begin
                s_key[i] = '0;
                s_data[i] = '0;
                s_len[i] = '0;
                s_used[i] = 0;
            end
            live_cnt = 0;
            tomb_cnt = 0;
            max_live = 1024;
            data_bytes = 8;
            errors = 0;
        endfunction

        function int step_of(logic [63:0] key);
            int s;
            s = int'(key % 64'(STEP_MOD));
            return (s == 0) ? 1 : s;
        endfunction

        // index of live slot holding key, -1 if absent
        function int find_live(logic [63:0] key);
            int first;
            int a;
            int stp;
            first = int'(key % 64'(TBL_SLOTS));
            stp = step_of(key);
            a = first;
            do
            begin
                if (!s_used[a])
                    return -1;
                if (s_len[a] != 0 && s_key[a] == key)
                    return a;
                a = (a + stp) % TBL_SLOTS;
            end while (a != first);
            return -1;
        endfunction

        function logic [1:0] do_insert(table_req_t r);
            int lim;
            int first;
            int a;
            int stp;
            lim = (data_bytes < 8) ? data_bytes : 8;
            if (r.len == 0 || int'(r.len) > lim)
                return dhkt_pkg::ST_BADLEN;
            if (live_cnt >= max_live)
                return dhkt_pkg::ST_FULL;
            first = int'(r.key % 64'(TBL_SLOTS));
            stp = step_of(r.key);
            a = first;
            do
            begin
                if (s_len[a] == 0)
                begin
                    // reusing a tombstone
                    if (s_used[a] && tomb_cnt > 0)
                        tomb_cnt--;
                    s_key[a] = r.key;
                    s_data[a] = (r.len >= 8) ? r.data
                                : (r.data & ((64'd1 << (8 * r.len)) - 64'd1));
                    s_len[a] = r.len;
                    s_used[a] = 1;
                    live_cnt++;
                    return dhkt_pkg::ST_OK;
                end
                a = (a + stp) % TBL_SLOTS;
            end while (a != first);
            return dhkt_pkg::ST_FULL;
        endfunction

        // accepted request: update the table and queue its response
        function void note_request(table_req_t r);
            table_rsp_t e;
            int s;
            e = '{dhkt_pkg::ST_NOTFOUND, '0, '0, '0, '0, '0};
            case (r.action)
                dhkt_pkg::ACT_INSERT: e.status = do_insert(r);
                dhkt_pkg::ACT_LOOKUP:
                begin
                    s = find_live(r.key);
                    if (s >= 0)
                    begin
                        e.status = dhkt_pkg::ST_OK;
                        e.odata = s_data[s];
                        e.olen = s_len[s];
                    end
                end
                dhkt_pkg::ACT_REMOVE:
                begin
                    s = find_live(r.key);
                    if (s >= 0)
                    begin
                        e.status = dhkt_pkg::ST_OK;
                        s_len[s] = 0;
                        if (live_cnt > 0)
                            live_cnt--;
                        tomb_cnt++;
                    end
                end
                default:
                begin
                    for (int i = int'(r.sidx); i < TBL_SLOTS; i++)
                    begin
                        if (s_len[i] != 0)
                        begin
                            e.status = dhkt_pkg::ST_OK;
                            e.okey = s_key[i];
                            e.resume = 11'(i + 1);
                            break;
                        end
                    end
                end
            endcase
            e.live = 11'(live_cnt);
            pending_rsp.push_back(e);
        endfunction

        function void check_response(table_rsp_t got);
            table_rsp_t e;
            if (pending_rsp.size() == 0)
            begin
                $error("response with nothing expected");
                errors++;
                return;
            end
            e = pending_rsp.pop_front();
            if (got.status !== e.status)
            begin
                $error("status: expected %0d got %0d", e.status, got.status);
                errors++;
            end
            if (got.odata !== e.odata)
            begin
                $error("out_data: expected %h got %h", e.odata, got.odata);
                errors++;
            end
            if (got.olen !== e.olen)
            begin
                $error("out_length: expected %0d got %0d", e.olen, got.olen);
                errors++;
            end
            if (got.okey !== e.okey)
            begin
                $error("out_key: expected %h got %h", e.okey, got.okey);
                errors++;
            end
            if (got.resume !== e.resume)
            begin
                $error("resume_index: expected %0d got %0d", e.resume, got.resume);
                errors++;
            end
            if (got.live !== e.live)
            begin
                $error("live_entries: expected %0d got %0d", e.live, got.live);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic        cfg_index = 0;
    logic [10:0] cfg_data = '0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [1:0]  action = '0;
    logic [63:0] key_hash = '0;
    logic [63:0] data_word = '0;
    logic [3:0]  data_len = '0;
    logic [10:0] start_index = '0;
    logic        out_valid;
    logic        out_ready = 0;
    logic [1:0]  status;
    logic [63:0] out_data;
    logic [3:0]  out_length;
    logic [63:0] out_key;
    logic [10:0] resume_index;
    logic [10:0] live_entries;

    key_table_board board;
    logic [63:0] key_pool[$];
    bit     steady = 0;    // no idling on either side while set
    longint cycles = 0;

    double_hash_key_table DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .key_hash(key_hash), .data_word(data_word),
        .data_len(data_len), .start_index(start_index),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .out_data(out_data), .out_length(out_length),
        .out_key(out_key), .resume_index(resume_index), .live_entries(live_entries)
    );

    always #10 clk = ~clk;

    // receiver stalls at random
    always @(negedge clk)
        out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 31);

    // every handshaked result goes to the board
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_response('{status, out_data, out_length, out_key,
                                   resume_index, live_entries});
    end

    // hard stop; the clearing pass and full-table probes are covered many times over
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_double_hash_key_table NOT OK");
            $finish;
        end
    end

    // called at a falling edge, returns at a falling edge after the item is taken
    task automatic send_item(table_req_t r);
        while (!steady && $urandom_range(99) < 31)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        action <= r.action;
        key_hash <= r.key;
        data_word <= r.data;
        data_len <= r.len;
        start_index <= r.sidx;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_request(r);
        @(negedge clk);
    endtask

    task automatic send_op(logic [1:0] act, logic [63:0] key, logic [63:0] data,
                           logic [3:0] len, logic [10:0] sidx);
        table_req_t r;
        r = '{act, key, data, len, sidx};
        if (act == dhkt_pkg::ACT_INSERT)
            key_pool.push_back(key);
        send_item(r);
    endtask

    // wait for the block to drain, then write both registers
    task automatic set_config(int live_max, int bytes);
        in_valid <= 1'b0;
        @(negedge clk);
        while (board.pending_rsp.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= dhkt_pkg::CFG_MAX_LIVE;
        cfg_data <= 11'(live_max);
        @(negedge clk);
        cfg_index <= dhkt_pkg::CFG_DATA_BYTES;
        cfg_data <= 11'(bytes);
        @(negedge clk);
        cfg_we <= 1'b0;
        board.max_live = live_max;
        board.data_bytes = bytes;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_key();
        int sel;
        sel = $urandom_range(99);
        if (key_pool.size() == 0 || sel < 30)
            return rand64();
        if (sel < 40)   // same home slot as a known key
            return key_pool[$urandom_range(key_pool.size() - 1)]
                   + 64'(TBL_SLOTS * $urandom_range(1, 3));
        return key_pool[$urandom_range(key_pool.size() - 1)];
    endfunction

    task automatic random_items(int count);
        int sel;
        logic [3:0] len;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(99);
            len = ($urandom_range(99) < 85) ? 4'($urandom_range(1, 8))
                                             : 4'($urandom_range(0, 15));
            if (sel < 35)
                send_op(dhkt_pkg::ACT_INSERT, pick_key(), rand64(), len, 11'($urandom));
            else if (sel < 65)
                send_op(dhkt_pkg::ACT_LOOKUP, pick_key(), rand64(), len, 11'($urandom));
            else if (sel < 85)
                send_op(dhkt_pkg::ACT_REMOVE, pick_key(), rand64(), len, 11'($urandom));
            else
                send_op(dhkt_pkg::ACT_NEXT, rand64(), rand64(), len,
                        ($urandom_range(1) == 1) ? 11'($urandom_range(900, 2047))
                                                 : 11'($urandom));
            if (key_pool.size() > 400)
                void'(key_pool.pop_front());
        end
    endtask

    initial
    begin
        logic [63:0] home;
        logic [10:0] scan_at;
        board = new();
        board.clear();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: lengths, extreme keys, collisions, tombstones, scan range
        home = 64'd5;
        send_op(dhkt_pkg::ACT_INSERT, 64'd0, '1, 4'd8, '0);
        send_op(dhkt_pkg::ACT_INSERT, '1, 64'h0123_4567_89ab_cdef, 4'd1, '0);
        send_op(dhkt_pkg::ACT_INSERT, 64'd77, '1, 4'd0, '0);
        send_op(dhkt_pkg::ACT_INSERT, 64'd77, '1, 4'd9, '0);
        send_op(dhkt_pkg::ACT_INSERT, 64'd77, '1, 4'd15, '1);
        send_op(dhkt_pkg::ACT_INSERT, 64'(STEP_MOD * 5), '1, 4'd3, '0);   // zero step
        send_op(dhkt_pkg::ACT_INSERT, home, rand64(), 4'd4, '0);
        send_op(dhkt_pkg::ACT_INSERT, home + TBL_SLOTS, rand64(), 4'd7, '0);
        send_op(dhkt_pkg::ACT_LOOKUP, home + TBL_SLOTS, '0, '0, '0);
        send_op(dhkt_pkg::ACT_REMOVE, home, '0, '0, '0);
        send_op(dhkt_pkg::ACT_LOOKUP, home + TBL_SLOTS, '0, '0, '0);      // probe past tombstone
        send_op(dhkt_pkg::ACT_INSERT, home + 2 * TBL_SLOTS, rand64(), 4'd2, '0);
        send_op(dhkt_pkg::ACT_LOOKUP, home, '0, '0, '0);
        send_op(dhkt_pkg::ACT_REMOVE, home, '0, '0, '0);
        send_op(dhkt_pkg::ACT_LOOKUP, '1, '0, '0, '0);
        send_op(dhkt_pkg::ACT_INSERT, 64'd0, rand64(), 4'd4, '0);         // duplicate key
        send_op(dhkt_pkg::ACT_LOOKUP, 64'd0, '0, '0, '0);
        send_op(dhkt_pkg::ACT_LOOKUP, 64'(STEP_MOD * 5), '0, '0, '0);
        send_op(dhkt_pkg::ACT_NEXT, '0, '0, '0, 11'd0);
        send_op(dhkt_pkg::ACT_NEXT, '0, '0, '0, 11'd1152);
        send_op(dhkt_pkg::ACT_NEXT, '0, '0, '0, 11'd1153);
        send_op(dhkt_pkg::ACT_NEXT, '0, '0, '0, 11'd2047);

        // length limit and live limit at their extremes
        set_config(0, 3);
        send_op(dhkt_pkg::ACT_INSERT, rand64(), rand64(), 4'd3, '0);
        send_op(dhkt_pkg::ACT_INSERT, rand64(), rand64(), 4'd4, '0);
        send_op(dhkt_pkg::ACT_LOOKUP, 64'd0, '0, '0, '0);
        set_config(300, 1);
        send_op(dhkt_pkg::ACT_INSERT, rand64(), rand64(), 4'd1, '0);
        send_op(dhkt_pkg::ACT_INSERT, rand64(), rand64(), 4'd2, '0);

        // random phases under several settings, one stretch without idling
        set_config(1024, 8);
        random_items(60);
        steady = 1;
        random_items(40);
        steady = 0;
        set_config(40, 4);
        random_items(40);
        set_config(1151, 6);
        random_items(40);

        // fill every slot, then an insert refused at the live limit and lookups that wrap the probe
        set_config(1153, 8);
        while (board.live_cnt < TBL_SLOTS)
            send_op(dhkt_pkg::ACT_INSERT, rand64(), rand64(), 4'($urandom_range(1, 8)), '0);
        send_op(dhkt_pkg::ACT_INSERT, rand64(), rand64(), 4'd8, '0);
        send_op(dhkt_pkg::ACT_LOOKUP, rand64(), '0, '0, '0);
        send_op(dhkt_pkg::ACT_LOOKUP, rand64(), '0, '0, '0);
        set_config(1024, 8);
        send_op(dhkt_pkg::ACT_INSERT, rand64(), rand64(), 4'd8, '0);
        scan_at = '0;
        for (int n = 0; n < 12; n++)
        begin
            send_op(dhkt_pkg::ACT_NEXT, '0, '0, '0, scan_at);
            scan_at = board.pending_rsp[$].resume;
        end
        random_items(40);

        in_valid <= 1'b0;
        while (board.pending_rsp.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (board.errors == 0)
            $display("tb_double_hash_key_table OK");
        else
            $display("tb_double_hash_key_table NOT OK");
        $finish;
    end
endmodule
